// File: src/tje_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tje_pkg
// shared types, register indexes and fixed field widths of the tricorn
// julia escape-time block
// ----------------------------------------------------------------------------
package tje_pkg;

  localparam int IN_W       = 48;
  localparam int C_W        = 48;
  localparam int TRIG_W     = 30;
  localparam int RAD_W      = 36;
  localparam int LIM_W      = 16;
  localparam int COLOR_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int COLOR_STEP    = 8;
  localparam int NEG_IM_OFFSET = 21;

  // reset values of the configuration registers
  localparam logic [C_W-1:0]    C_REAL_RESET = 48'hFFFF_F000_0000;
  localparam logic [C_W-1:0]    C_IMAG_RESET = 48'h0;
  localparam logic [TRIG_W-1:0] COS_RESET    = 30'd268435456;
  localparam logic [TRIG_W-1:0] SIN_RESET    = 30'd0;
  localparam logic [RAD_W-1:0]  RAD_RESET    = 36'd26843545600;
  localparam logic [LIM_W-1:0]  LIM_RESET    = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C_REAL,
    REG_C_IMAG,
    REG_COS_C,
    REG_SIN_C,
    REG_COS_Z,
    REG_SIN_Z,
    REG_RADIUS,
    REG_LIMIT
  } cfg_reg_t;

  typedef struct packed {
    logic [C_W-1:0]    c_real;
    logic [C_W-1:0]    c_imag;
    logic [TRIG_W-1:0] cos_c_angle;
    logic [TRIG_W-1:0] sin_c_angle;
    logic [TRIG_W-1:0] cos_z_angle;
    logic [TRIG_W-1:0] sin_z_angle;
    logic [RAD_W-1:0]  escape_radius;
    logic [LIM_W-1:0]  iteration_limit;
  } cfg_t;

  // operand sets fed to the three product units
  typedef enum logic [1:0] {
    OP_ROT1,
    OP_ROT2,
    OP_ROT3,
    OP_SQ
  } op_sel_t;

  typedef struct packed {
    logic    load_in;
    op_sel_t op_sel;
    logic    cap_rot1;
    logic    cap_rot2;
    logic    cap_rot3;
    logic    step;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic cont;
  } dp_status_t;

endpackage
`default_nettype wire

// File: src/tje_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tje_cfg
// configuration register file, written one register per beat
// ----------------------------------------------------------------------------
module tje_cfg import tje_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // no beat is taken while reset holds the defaults
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c_real          <= C_REAL_RESET;
      cfg.c_imag          <= C_IMAG_RESET;
      cfg.cos_c_angle     <= COS_RESET;
      cfg.sin_c_angle     <= SIN_RESET;
      cfg.cos_z_angle     <= COS_RESET;
      cfg.sin_z_angle     <= SIN_RESET;
      cfg.escape_radius   <= RAD_RESET;
      cfg.iteration_limit <= LIM_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_C_REAL: cfg.c_real          <= cfg_data[C_W-1:0];
        REG_C_IMAG: cfg.c_imag          <= cfg_data[C_W-1:0];
        REG_COS_C:  cfg.cos_c_angle     <= cfg_data[TRIG_W-1:0];
        REG_SIN_C:  cfg.sin_c_angle     <= cfg_data[TRIG_W-1:0];
        REG_COS_Z:  cfg.cos_z_angle     <= cfg_data[TRIG_W-1:0];
        REG_SIN_Z:  cfg.sin_z_angle     <= cfg_data[TRIG_W-1:0];
        REG_RADIUS: cfg.escape_radius   <= cfg_data[RAD_W-1:0];
        REG_LIMIT:  cfg.iteration_limit <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/tje_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tje_mul
// two-stage fixed-point multiplier: half-width partial products, then
// reduction, truncating shift of the magnitude and saturation
// ----------------------------------------------------------------------------
module tje_mul #(
  parameter int W = 48,
  parameter int F = 28
) (
  input  logic                clk,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic signed [W-1:0] q
);

  localparam int H  = (W + 1) / 2;
  localparam int PW = 4 * H;
  localparam logic [W-1:0]  VMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  VMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] VMAX_P = {{(PW-W){1'b0}}, VMAX};

  logic [W-1:0]   mag_a, mag_b;
  logic [H-1:0]   a_lo, a_hi, b_lo, b_hi;
  logic [2*H-1:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic           neg;
  logic [PW-1:0]  full, shifted;
  logic [W-1:0]   q_next;

  // most negative value maps to 2^(W-1), which still fits unsigned
  assign mag_a = a[W-1] ? W'(-a) : W'(a);
  assign mag_b = b[W-1] ? W'(-b) : W'(b);
  assign a_lo  = mag_a[H-1:0];
  assign a_hi  = H'(mag_a >> H);
  assign b_lo  = mag_b[H-1:0];
  assign b_hi  = H'(mag_b >> H);

  always_ff @(posedge clk) begin
    pp_ll <= (2*H)'(a_lo) * (2*H)'(b_lo);
    pp_lh <= (2*H)'(a_lo) * (2*H)'(b_hi);
    pp_hl <= (2*H)'(a_hi) * (2*H)'(b_lo);
    pp_hh <= (2*H)'(a_hi) * (2*H)'(b_hi);
    neg   <= a[W-1] ^ b[W-1];
  end

  always_comb begin
    full = PW'(pp_ll) + (PW'(pp_lh) << H) + (PW'(pp_hl) << H) + (PW'(pp_hh) << (2*H));
    shifted = full >> F;
    if (shifted > VMAX_P) begin
      q_next = neg ? VMIN : VMAX;
    end else if (neg) begin
      q_next = W'(-shifted);
    end else begin
      q_next = shifted[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
`default_nettype wire

// File: src/tje_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tje_dp
// datapath: operand selection for three product units, rotation and
// iteration registers, escape test and color computation
// ----------------------------------------------------------------------------
module tje_dp import tje_pkg::*; #(
  parameter int W = 48,
  parameter int F = 28
) (
  input  logic               clk,
  input  logic [IN_W-1:0]    point_x,
  input  logic [IN_W-1:0]    point_y,
  input  cfg_t               cfg,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  output logic               bounded,
  output logic [COLOR_W-1:0] color_index
);

  localparam int XW = (W > IN_W ? W : IN_W) + 1;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] VMAX_X = {{(XW-W){1'b0}}, VMAX};
  localparam logic signed [XW-1:0] VMIN_X = {{(XW-W){1'b1}}, VMIN};

  function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
    if (v > VMAX_X) begin
      return VMAX;
    end else if (v < VMIN_X) begin
      return VMIN;
    end
    return v[W-1:0];
  endfunction

  function automatic logic signed [XW-1:0] xv(input logic signed [W-1:0] v);
    return {{(XW-W){v[W-1]}}, v};
  endfunction

  function automatic logic signed [XW-1:0] x_in(input logic [IN_W-1:0] v);
    return {{(XW-IN_W){v[IN_W-1]}}, v};
  endfunction

  function automatic logic signed [XW-1:0] x_trig(input logic [TRIG_W-1:0] v);
    return {{(XW-TRIG_W){v[TRIG_W-1]}}, v};
  endfunction

  logic signed [W-1:0] cr, ci, cc, sc, cz, sz, rad;
  logic signed [W-1:0] x, y, re, im, are, aim, r2;
  logic [LIM_W-1:0]    cnt;
  logic                res_bounded;
  logic [COLOR_W-1:0]  res_color;

  logic signed [W-1:0] a0, b0, a1, b1, a2, b2, q0, q1, q2;
  logic signed [W-1:0] mag2, re_new, dbl, ndbl, im_new;
  logic                cnt_ok;
  logic [COLOR_W-1:0]  color_next;

  assign cr  = sat(x_in(cfg.c_real));
  assign ci  = sat(x_in(cfg.c_imag));
  assign cc  = sat(x_trig(cfg.cos_c_angle));
  assign sc  = sat(x_trig(cfg.sin_c_angle));
  assign cz  = sat(x_trig(cfg.cos_z_angle));
  assign sz  = sat(x_trig(cfg.sin_z_angle));
  assign rad = sat({{(XW-RAD_W){1'b0}}, cfg.escape_radius});

  always_comb begin
    case (cmd.op_sel)
      OP_ROT1: begin
        a0 = cz; b0 = x;  a1 = sz; b1 = y;  a2 = rad; b2 = rad;
      end
      OP_ROT2: begin
        a0 = sz; b0 = x;  a1 = cz; b1 = y;  a2 = cc;  b2 = cr;
      end
      OP_ROT3: begin
        a0 = sc; b0 = ci; a1 = sc; b1 = cr; a2 = cc;  b2 = ci;
      end
      OP_SQ: begin
        a0 = re; b0 = re; a1 = im; b1 = im; a2 = re;  b2 = im;
      end
      default: begin
        a0 = re; b0 = re; a1 = im; b1 = im; a2 = re;  b2 = im;
      end
    endcase
  end

  tje_mul #(.W(W), .F(F)) u_mul0 (.clk(clk), .a(a0), .b(b0), .q(q0));
  tje_mul #(.W(W), .F(F)) u_mul1 (.clk(clk), .a(a1), .b(b1), .q(q1));
  tje_mul #(.W(W), .F(F)) u_mul2 (.clk(clk), .a(a2), .b(b2), .q(q2));

  // during the test step q0, q1, q2 hold re^2, im^2 and re*im
  always_comb begin
    mag2   = sat(xv(q0) + xv(q1));
    cnt_ok = cnt < cfg.iteration_limit;
    re_new = sat(xv(sat(xv(q0) - xv(q1))) + xv(are));
    dbl    = sat(xv(q2) + xv(q2));
    ndbl   = sat(-xv(dbl));
    im_new = sat(xv(ndbl) + xv(aim));
    color_next = COLOR_W'(cnt) * COLOR_W'(COLOR_STEP)
               + (im[W-1] ? COLOR_W'(NEG_IM_OFFSET) : '0);
  end

  assign status.cont = cnt_ok && (mag2 < r2);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x <= sat(x_in(point_x));
      y <= sat(x_in(point_y));
    end
    if (cmd.cap_rot1) begin
      re <= sat(xv(q0) - xv(q1));
      r2 <= q2;
    end
    if (cmd.cap_rot2) begin
      im  <= sat(xv(q0) + xv(q1));
      are <= q2;
    end
    if (cmd.cap_rot3) begin
      are <= sat(xv(are) - xv(q0));
      aim <= sat(xv(q1) + xv(q2));
      cnt <= '0;
    end
    if (cmd.step) begin
      if (status.cont) begin
        re  <= re_new;
        im  <= im_new;
        cnt <= cnt + 1'b1;
      end else begin
        res_bounded <= !cnt_ok;
        res_color   <= cnt_ok ? color_next : '0;
      end
    end
    if (cmd.load_out) begin
      bounded     <= res_bounded;
      color_index <= res_color;
    end
  end

endmodule
`default_nettype wire

// File: src/tje_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tje_ctrl
// controller: sequences the rotation rounds and the iteration loop,
// owns the input and output handshakes
// ----------------------------------------------------------------------------
module tje_ctrl import tje_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROT1,
    S_ROT2,
    S_ROT3,
    S_ROT4,
    S_ROT5,
    S_MUL,
    S_SUM,
    S_TEST,
    S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.op_sel   = OP_SQ;
    case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = S_ROT1;
        end
      end
      S_ROT1: begin
        cmd.op_sel = OP_ROT1;
        state_next = S_ROT2;
      end
      S_ROT2: begin
        cmd.op_sel = OP_ROT2;
        state_next = S_ROT3;
      end
      S_ROT3: begin
        cmd.op_sel   = OP_ROT3;
        cmd.cap_rot1 = 1'b1;
        state_next   = S_ROT4;
      end
      S_ROT4: begin
        cmd.cap_rot2 = 1'b1;
        state_next   = S_ROT5;
      end
      // c rotation finishes while the first squares start
      S_ROT5: begin
        cmd.cap_rot3 = 1'b1;
        state_next   = S_SUM;
      end
      S_MUL: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        state_next = S_TEST;
      end
      S_TEST: begin
        cmd.step   = 1'b1;
        state_next = status.cont ? S_MUL : S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a point is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before its beat");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the finish state");

  a_exit_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_TEST && !status.cont) |=> (state == S_DONE))
    else $error("loop exit did not reach the finish state");
`endif

endmodule
`default_nettype wire

// File: src/tricorn_julia_escape_time.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tricorn_julia_escape_time
// escape-time iteration of z -> conj(z)^2 + c on a rotated start point
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes one start point per beat;
//   output channel (out_valid/out_ready) returns one result per point:
//   bounded, or a color index of 8*n plus 21 for a negative final imag part.
//   config channel (cfg_valid/cfg_ready) writes one register per beat and is
//   ready whenever reset is low; write it only while no point is in flight.
// timing:
//   one point at a time; the result shows on the output in the same cycle
//   that in_ready returns, and the next point can be taken from then on.
//   each iteration runs through S_MUL, S_SUM and S_TEST: the two-stage product
//   units form re^2, im^2 and re*im, then S_TEST tests the radius and updates z.
//   the rotations of z0 and c share the same three units in S_ROT1 to S_ROT5.
// reset: rst clears the controller and loads the register defaults
//   (c = -1, no rotation, radius 100, limit 100); no beat is taken during it.
// stalls: the result waits in an output register; a new point is accepted
//   meanwhile, and the block holds in its finish state only if a second
//   result is ready before the first beat is taken.
// ----------------------------------------------------------------------------
module tricorn_julia_escape_time import tje_pkg::*; #(
  parameter int FRAC_BITS   = 28,
  parameter int VALUE_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [IN_W-1:0]       point_x,
  input  logic [IN_W-1:0]       point_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  bounded,
  output logic [COLOR_W-1:0]    color_index,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  tje_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tje_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tje_dp #(.W(VALUE_WIDTH), .F(FRAC_BITS)) u_dp (
    .clk         (clk),
    .point_x     (point_x),
    .point_y     (point_y),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .bounded     (bounded),
    .color_index (color_index)
  );

endmodule
`default_nettype wire
